[src/option_pde_residual_stencil_unit_assert.svh]
// Assertion macros for the residual stencil unit.
`ifndef OPTION_PDE_RESIDUAL_STENCIL_UNIT_ASSERT_SVH
`define OPTION_PDE_RESIDUAL_STENCIL_UNIT_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define OPDR_ASSERT_NOW(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define OPDR_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/opdr_pkg.sv]
`default_nettype none

package opdr_pkg;

  // Grid size along price; indices past the grid clip to the last row
  localparam int PRICE_POINTS = 4096;
  localparam logic [11:0] IDX_MAX =
    (PRICE_POINTS - 1 > 4095) ? 12'd4095 : 12'(PRICE_POINTS - 1);

  // Edge codes (price: lowest/highest row, time: first/last column); others are interior
  localparam logic [1:0] EDGE_FIRST = 2'd1;
  localparam logic [1:0] EDGE_LAST  = 2'd2;

  // Configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_HALF_SIGMA_SQ     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RATE              = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_PRICE        = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INV_STEP_PRICE    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_INV_STEP_PRICE_SQ = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_INV_STEP_TIME     = 3'd5;

  localparam logic [31:0] HALF_SIGMA_SQ_RST = 32'd1311;
  localparam logic [31:0] RATE_RST          = 32'd3277;
  localparam logic [31:0] UNIT_RST          = 32'd65536;

  // Product magnitudes clip at 2^MAG_W - 1
  localparam int MAG_W   = 60;
  // Register stages in one wide multiply
  localparam int MUL_LAT = 4;

  // Price S = index * step
  localparam int S_W = 44;

  localparam logic signed [31:0] RES_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] RES_MIN = 32'sh8000_0000;

  typedef struct packed {
    logic        [11:0] price_index;
    logic        [1:0]  price_edge;
    logic        [1:0]  time_edge;
    logic signed [31:0] v_center;
    logic signed [31:0] v_price_below;
    logic signed [31:0] v_price_above;
    logic signed [31:0] v_price_far;
    logic signed [31:0] v_time_before;
    logic signed [31:0] v_time_after;
  } in_t;

  typedef struct packed {
    logic signed [31:0] residual;
    logic               saturated;
  } out_t;

endpackage

`default_nettype wire

[src/opdr_qmul.sv]
`default_nettype none

// Sign-magnitude multiply, up to 64x64, four stages:
// 32x32 partials, middle/rounding adds, full add, shift and clip.
// Rounds to nearest, ties away from zero; shift is 16, or 17 when half is set.
module opdr_qmul #(
  parameter int AW = 32,
  parameter int BW = 32,
  parameter int OW = 60
) (
  input  logic          clk,
  input  logic [AW-1:0] a_mag,
  input  logic [BW-1:0] b_mag,
  input  logic          neg,
  input  logic          half,
  output logic [OW-1:0] p_mag,
  output logic          p_neg
);

  localparam logic [64:0] RND_16 = 65'd32768;
  localparam logic [64:0] RND_17 = 65'd65536;

  logic [63:0]  a64, b64;
  logic [63:0]  p00_r, p01_r, p10_r, p11_r;
  logic         neg1_r, half1_r;
  logic [64:0]  mid_r, lo_r;
  logic [63:0]  p11b_r;
  logic         neg2_r, half2_r;
  logic [127:0] full_nxt, full_r;
  logic         neg3_r, half3_r;
  logic [127:0] shf;
  logic [opdr_pkg::MAG_W-1:0] mag_c;
  logic [OW-1:0] p_mag_r;
  logic          p_neg_r;

  assign a64 = 64'(a_mag);
  assign b64 = 64'(b_mag);

  always_ff @(posedge clk) begin
    p00_r   <= 64'(a64[31:0])  * 64'(b64[31:0]);
    p01_r   <= 64'(a64[31:0])  * 64'(b64[63:32]);
    p10_r   <= 64'(a64[63:32]) * 64'(b64[31:0]);
    p11_r   <= 64'(a64[63:32]) * 64'(b64[63:32]);
    neg1_r  <= neg;
    half1_r <= half;
  end

  always_ff @(posedge clk) begin
    mid_r   <= {1'b0, p01_r} + {1'b0, p10_r};
    lo_r    <= {1'b0, p00_r} + (half1_r ? RND_17 : RND_16);
    p11b_r  <= p11_r;
    neg2_r  <= neg1_r;
    half2_r <= half1_r;
  end

  assign full_nxt = {p11b_r, 64'd0} + {31'd0, mid_r, 32'd0} + {63'd0, lo_r};

  always_ff @(posedge clk) begin
    full_r  <= full_nxt;
    neg3_r  <= neg2_r;
    half3_r <= half2_r;
  end

  always_comb begin
    shf   = half3_r ? (full_r >> 17) : (full_r >> 16);
    mag_c = (|shf[127:opdr_pkg::MAG_W]) ? '1 : shf[opdr_pkg::MAG_W-1:0];
  end

  always_ff @(posedge clk) begin
    p_mag_r <= mag_c[OW-1:0];
    p_neg_r <= neg3_r;
  end

  assign p_mag = p_mag_r;
  assign p_neg = p_neg_r;

endmodule

`default_nettype wire

[src/option_pde_residual_stencil_unit.sv]
// Channel   Ports                                   Handshake
// input     start, busy, in_data                    taken when start && !busy
// result    out_valid, out_data                     one-cycle strobe, no back-pressure
// config    cfg_valid, cfg_ready, cfg_index/wdata   written when cfg_valid && cfg_ready
//
// One item per cycle. An item's result passes the input register, the difference and
// sign-magnitude banks, three wide multiplies (four stages each) and the sum and clip registers.
// busy stays low: the pipeline never stalls as results cannot be held off.
// Synchronous active-low reset clears the valid chain and loads register defaults.
// The user writes configuration only while no item is in flight; the block does not enforce it.
`default_nettype none
`include "option_pde_residual_stencil_unit_assert.svh"

module option_pde_residual_stencil_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  opdr_pkg::in_t                     in_data,
  output logic                              out_valid,
  output opdr_pkg::out_t                    out_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [opdr_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [31:0]                       cfg_wdata
);

  localparam int ML    = opdr_pkg::MUL_LAT;
  localparam int SW    = opdr_pkg::S_W;
  localparam int DEPTH = 3 * ML + 7;
  localparam int T1_BANK = 3 * ML + 2;

  // configuration
  logic [31:0] hss_r, rate_mag_r, step_r, inv_sp_r, inv_sp_sq_r, inv_st_r;
  logic        rate_neg_r;

  logic [DEPTH-1:0] vld_r;
  logic             accept;

  // bank 0
  opdr_pkg::in_t in_r;

  // bank 1
  logic [11:0] idx_c;
  logic [33:0] ex_c, ex_b, ex_a, ex_f, ex_tb, ex_ta;
  logic [33:0] d1_w, d2_w, dt_w;
  logic        d1h_nxt, dth_nxt;
  logic [32:0] d1_r, dt_r;
  logic [33:0] d2_r;
  logic        d1h_r, dth_r;
  logic [31:0] vc_r;
  logic [SW-1:0] s_r;

  // bank 2
  logic [32:0] d1_abs, dt_abs;
  logic [33:0] d2_abs;
  logic [31:0] vc_abs;
  logic [31:0] d1m_r, dtm_r, vcm_r;
  logic [32:0] d2m_r;
  logic        d1n_r, d2n_r, dtn_r, vcn_r, d1h2_r, dth2_r;
  logic [ML:0][SW-1:0] s_dly_r;

  // products
  logic [47:0] d1s_mag, d1t_mag;
  logic [48:0] d2s_mag;
  logic [59:0] h1_mag, h2_mag, t1_mag, t2_mag;
  logic [58:0] r1_mag;
  logic [46:0] t3_mag;
  logic        d1s_neg, d1t_neg, d2s_neg, h1_neg, h2_neg, t1_neg, t2_neg, r1_neg, t3_neg;

  logic [ML-1:0][49:0]   d2s_dly_r;
  logic [2*ML-1:0][48:0] d1t_dly_r;
  logic [2*ML-1:0][47:0] t3_dly_r;
  logic [ML-1:0][60:0]   t2_dly_r;

  // final sum
  logic signed [60:0] ta_nxt, tb_nxt, tc_nxt, td_nxt;
  logic signed [60:0] ta_r, tb_r, tc_r, td_r;
  logic signed [61:0] pa_r, pb_r;
  logic signed [62:0] sum_r;
  opdr_pkg::out_t     out_nxt, out_r;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hss_r       <= opdr_pkg::HALF_SIGMA_SQ_RST;
      rate_mag_r  <= opdr_pkg::RATE_RST;
      rate_neg_r  <= 1'b0;
      step_r      <= opdr_pkg::UNIT_RST;
      inv_sp_r    <= opdr_pkg::UNIT_RST;
      inv_sp_sq_r <= opdr_pkg::UNIT_RST;
      inv_st_r    <= opdr_pkg::UNIT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        opdr_pkg::REG_HALF_SIGMA_SQ:     hss_r <= cfg_wdata;
        opdr_pkg::REG_RATE: begin
          // kept as sign and magnitude for the multipliers
          rate_neg_r <= cfg_wdata[31];
          rate_mag_r <= cfg_wdata[31] ? (~cfg_wdata + 32'd1) : cfg_wdata;
        end
        opdr_pkg::REG_STEP_PRICE:        step_r      <= cfg_wdata;
        opdr_pkg::REG_INV_STEP_PRICE:    inv_sp_r    <= cfg_wdata;
        opdr_pkg::REG_INV_STEP_PRICE_SQ: inv_sp_sq_r <= cfg_wdata;
        opdr_pkg::REG_INV_STEP_TIME:     inv_st_r    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[DEPTH-2:0], accept};
    end
  end

  always_ff @(posedge clk) begin
    in_r <= in_data;
  end

  // bank 1: stencil differences and price
  always_comb begin
    idx_c = (in_r.price_index > opdr_pkg::IDX_MAX) ? opdr_pkg::IDX_MAX : in_r.price_index;
    ex_c  = {{2{in_r.v_center[31]}}, in_r.v_center};
    ex_b  = {{2{in_r.v_price_below[31]}}, in_r.v_price_below};
    ex_a  = {{2{in_r.v_price_above[31]}}, in_r.v_price_above};
    ex_f  = {{2{in_r.v_price_far[31]}}, in_r.v_price_far};
    ex_tb = {{2{in_r.v_time_before[31]}}, in_r.v_time_before};
    ex_ta = {{2{in_r.v_time_after[31]}}, in_r.v_time_after};
    case (in_r.price_edge)
      opdr_pkg::EDGE_FIRST: begin
        d1_w    = ex_a - ex_c;
        d2_w    = ex_f - {ex_a[32:0], 1'b0} + ex_c;
        d1h_nxt = 1'b0;
      end
      opdr_pkg::EDGE_LAST: begin
        d1_w    = ex_c - ex_b;
        d2_w    = ex_c - {ex_b[32:0], 1'b0} + ex_f;
        d1h_nxt = 1'b0;
      end
      default: begin
        // central difference: the halving goes into the rounding shift
        d1_w    = ex_a - ex_b;
        d2_w    = ex_a - {ex_c[32:0], 1'b0} + ex_b;
        d1h_nxt = 1'b1;
      end
    endcase
    case (in_r.time_edge)
      opdr_pkg::EDGE_FIRST: begin
        dt_w    = ex_ta - ex_c;
        dth_nxt = 1'b0;
      end
      opdr_pkg::EDGE_LAST: begin
        dt_w    = ex_c - ex_tb;
        dth_nxt = 1'b0;
      end
      default: begin
        dt_w    = ex_ta - ex_tb;
        dth_nxt = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    d1_r  <= d1_w[32:0];
    d2_r  <= d2_w;
    dt_r  <= dt_w[32:0];
    d1h_r <= d1h_nxt;
    dth_r <= dth_nxt;
    vc_r  <= in_r.v_center;
    s_r   <= SW'(idx_c) * SW'(step_r);
  end

  // bank 2: to sign and magnitude
  always_comb begin
    d1_abs = d1_r[32] ? (~d1_r + 33'd1) : d1_r;
    d2_abs = d2_r[33] ? (~d2_r + 34'd1) : d2_r;
    dt_abs = dt_r[32] ? (~dt_r + 33'd1) : dt_r;
    vc_abs = vc_r[31] ? (~vc_r + 32'd1) : vc_r;
  end

  always_ff @(posedge clk) begin
    d1m_r   <= d1_abs[31:0];
    d1n_r   <= d1_r[32];
    d2m_r   <= d2_abs[32:0];
    d2n_r   <= d2_r[33];
    dtm_r   <= dt_abs[31:0];
    dtn_r   <= dt_r[32];
    vcm_r   <= vc_abs;
    vcn_r   <= vc_r[31];
    d1h2_r  <= d1h_r;
    dth2_r  <= dth_r;
    s_dly_r <= {s_dly_r[ML-1:0], s_r};
  end

  // first multiply rank
  opdr_qmul #(.AW(32), .BW(32), .OW(48)) u_d1s (
    .clk(clk), .a_mag(d1m_r), .b_mag(inv_sp_r), .neg(d1n_r), .half(d1h2_r),
    .p_mag(d1s_mag), .p_neg(d1s_neg)
  );

  opdr_qmul #(.AW(33), .BW(32), .OW(49)) u_d2s (
    .clk(clk), .a_mag(d2m_r), .b_mag(inv_sp_sq_r), .neg(d2n_r), .half(1'b0),
    .p_mag(d2s_mag), .p_neg(d2s_neg)
  );

  opdr_qmul #(.AW(32), .BW(32), .OW(48)) u_d1t (
    .clk(clk), .a_mag(dtm_r), .b_mag(inv_st_r), .neg(dtn_r), .half(dth2_r),
    .p_mag(d1t_mag), .p_neg(d1t_neg)
  );

  opdr_qmul #(.AW(32), .BW(SW), .OW(60)) u_h1 (
    .clk(clk), .a_mag(hss_r), .b_mag(s_dly_r[0]), .neg(1'b0), .half(1'b0),
    .p_mag(h1_mag), .p_neg(h1_neg)
  );

  opdr_qmul #(.AW(32), .BW(SW), .OW(59)) u_r1 (
    .clk(clk), .a_mag(rate_mag_r), .b_mag(s_dly_r[0]), .neg(rate_neg_r), .half(1'b0),
    .p_mag(r1_mag), .p_neg(r1_neg)
  );

  opdr_qmul #(.AW(32), .BW(32), .OW(47)) u_t3 (
    .clk(clk), .a_mag(rate_mag_r), .b_mag(vcm_r), .neg(rate_neg_r ^ vcn_r), .half(1'b0),
    .p_mag(t3_mag), .p_neg(t3_neg)
  );

  // second rank
  opdr_qmul #(.AW(60), .BW(SW), .OW(60)) u_h2 (
    .clk(clk), .a_mag(h1_mag), .b_mag(s_dly_r[ML]), .neg(h1_neg), .half(1'b0),
    .p_mag(h2_mag), .p_neg(h2_neg)
  );

  opdr_qmul #(.AW(59), .BW(48), .OW(60)) u_t2 (
    .clk(clk), .a_mag(r1_mag), .b_mag(d1s_mag), .neg(r1_neg ^ d1s_neg), .half(1'b0),
    .p_mag(t2_mag), .p_neg(t2_neg)
  );

  // third rank
  opdr_qmul #(.AW(60), .BW(49), .OW(60)) u_t1 (
    .clk(clk), .a_mag(h2_mag), .b_mag(d2s_dly_r[ML-1][48:0]),
    .neg(h2_neg ^ d2s_dly_r[ML-1][49]), .half(1'b0),
    .p_mag(t1_mag), .p_neg(t1_neg)
  );

  // align the shorter paths with the multiply chain
  always_ff @(posedge clk) begin
    d2s_dly_r <= {d2s_dly_r[ML-2:0], {d2s_neg, d2s_mag}};
    d1t_dly_r <= {d1t_dly_r[2*ML-2:0], {d1t_neg, d1t_mag}};
    t3_dly_r  <= {t3_dly_r[2*ML-2:0], {t3_neg, t3_mag}};
    t2_dly_r  <= {t2_dly_r[ML-2:0], {t2_neg, t2_mag}};
  end

  // back to two's complement; the rate * V term enters negated
  always_comb begin
    ta_nxt = d1t_dly_r[2*ML-1][48] ? (61'd0 - 61'(d1t_dly_r[2*ML-1][47:0]))
                                   : 61'(d1t_dly_r[2*ML-1][47:0]);
    tb_nxt = t1_neg ? (61'd0 - 61'(t1_mag)) : 61'(t1_mag);
    tc_nxt = t2_dly_r[ML-1][60] ? (61'd0 - 61'(t2_dly_r[ML-1][59:0]))
                                : 61'(t2_dly_r[ML-1][59:0]);
    td_nxt = t3_dly_r[2*ML-1][47] ? 61'(t3_dly_r[2*ML-1][46:0])
                                  : (61'd0 - 61'(t3_dly_r[2*ML-1][46:0]));
  end

  always_ff @(posedge clk) begin
    ta_r  <= ta_nxt;
    tb_r  <= tb_nxt;
    tc_r  <= tc_nxt;
    td_r  <= td_nxt;
    pa_r  <= {ta_r[60], ta_r} + {tb_r[60], tb_r};
    pb_r  <= {tc_r[60], tc_r} + {td_r[60], td_r};
    sum_r <= {pa_r[61], pa_r} + {pb_r[61], pb_r};
  end

  // clip to 32 bits
  always_comb begin
    if ((&sum_r[62:31]) || !(|sum_r[62:31])) begin
      out_nxt.residual  = sum_r[31:0];
      out_nxt.saturated = 1'b0;
    end else begin
      out_nxt.residual  = sum_r[62] ? opdr_pkg::RES_MIN : opdr_pkg::RES_MAX;
      out_nxt.saturated = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_valid = vld_r[DEPTH-1];
  assign out_data  = out_r;

  `OPDR_ASSERT_NOW(a_latency, clk, rst_n, out_valid, $past(accept, DEPTH), "result without item")
  `OPDR_ASSERT_NOW(a_t1_sign, clk, rst_n, vld_r[T1_BANK], t1_neg == $past(d2n_r, 3 * ML), "t1 sign lost")
  `OPDR_ASSERT_NEXT(a_rate_cfg, clk, rst_n, cfg_valid && cfg_ready && cfg_index == opdr_pkg::REG_RATE, rate_neg_r == $past(cfg_wdata[31]), "rate sign not stored")
  `OPDR_ASSERT_NOW(a_clip, clk, rst_n, out_valid && out_data.saturated, out_data.residual == opdr_pkg::RES_MAX || out_data.residual == opdr_pkg::RES_MIN, "clipped residual off bound")

endmodule

`default_nettype wire
